FILE: rtl/positional_array_list_core_assert.svh
// Assertion macros used by the positional array list datapath
`ifndef POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PAL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pal assertion failed");

// Consequent must hold in the cycle after the antecedent
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pal assertion failed");

`endif

FILE: rtl/pal_pkg.sv
// Shared constants, codes and interface types of the positional array list
`default_nettype none

package pal_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int POS_W      = 8;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BELOW  = 2'd1,
        ST_BEYOND = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef struct packed {
        logic load;
        logic exec;
    } pal_cmd_t;

    typedef struct packed {
        logic done;
    } pal_stat_t;

endpackage

`default_nettype wire

FILE: rtl/pal_ctrl.sv
// Controller state machine of the positional array list
`default_nettype none

module pal_ctrl
    import pal_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire pal_stat_t stat,
    output pal_cmd_t       cmd,
    output logic           busy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !stat.done)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || stat.done;

endmodule

`default_nettype wire

FILE: rtl/pal_datapath.sv
// Datapath of the positional array list: entry cells, checks and result registers
`default_nettype none
`include "positional_array_list_core_assert.svh"

module pal_datapath
    import pal_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pal_cmd_t              cmd,
    input  wire logic                  mode,
    input  wire logic [POS_W-1:0]      position,
    input  wire logic [DATA_WIDTH-1:0] value,
    output pal_stat_t                  stat,
    output logic [1:0]                 status,
    output logic [DATA_WIDTH-1:0]      removed_value,
    output logic [CNT_W-1:0]           count
);

    logic                  mode_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] value_reg;

    logic [DATA_WIDTH-1:0] entries_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] entries_next [CAPACITY];
    logic [DATA_WIDTH-1:0] up_src       [CAPACITY];
    logic [DATA_WIDTH-1:0] dn_src       [CAPACITY];

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    status_t               status_reg;
    status_t               status_next;
    logic [DATA_WIDTH-1:0] removed_reg;
    logic [DATA_WIDTH-1:0] removed_next;
    logic                  done_reg;

    logic [POS_W:0]        pos_ext;
    logic [POS_W:0]        cnt_ext;
    logic [POS_W-1:0]      pos_m1;
    logic                  op_ok;

    assign pos_ext = {1'b0, pos_reg};
    assign cnt_ext = (POS_W+1)'(count_reg);
    assign pos_m1  = pos_reg - POS_W'(1);

    always_comb
    begin
        up_src[0]          = entries_reg[0];
        dn_src[CAPACITY-1] = entries_reg[CAPACITY-1];
        for (int j = 1; j < CAPACITY; j++)
        begin
            up_src[j]   = entries_reg[j-1];
            dn_src[j-1] = entries_reg[j];
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        if (pos_reg == '0)
        begin
            status_next = ST_BELOW;
        end
        else if (mode_reg == MODE_INSERT)
        begin
            if (pos_ext > cnt_ext + (POS_W+1)'(1))
            begin
                status_next = ST_BEYOND;
            end
            else if (count_reg == CNT_W'(CAPACITY))
            begin
                status_next = ST_FULL;
            end
        end
        else
        begin
            if (pos_ext > cnt_ext)
            begin
                status_next = ST_BEYOND;
            end
        end
    end

    assign op_ok = (status_next == ST_OK);

    always_comb
    begin
        count_next   = count_reg;
        removed_next = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            entries_next[j] = entries_reg[j];
        end
        if (op_ok)
        begin
            if (mode_reg == MODE_INSERT)
            begin
                count_next = count_reg + CNT_W'(1);
                for (int j = 0; j < CAPACITY; j++)
                begin
                    if (POS_W'(j) == pos_m1)
                    begin
                        entries_next[j] = value_reg;
                    end
                    else if (POS_W'(j) > pos_m1)
                    begin
                        entries_next[j] = up_src[j];
                    end
                end
            end
            else
            begin
                count_next   = count_reg - CNT_W'(1);
                removed_next = entries_reg[pos_m1[IDX_W-1:0]];
                for (int j = 0; j < CAPACITY; j++)
                begin
                    if (POS_W'(j) >= pos_m1)
                    begin
                        entries_next[j] = dn_src[j];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            pos_reg   <= position;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            if (op_ok)
            begin
                for (int j = 0; j < CAPACITY; j++)
                begin
                    entries_reg[j] <= entries_next[j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign stat.done     = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign count         = count_reg;

    `PAL_ASSERT_NEXT(a_exec_done, clk, rst_n, cmd.exec, done_reg)
    `PAL_ASSERT_SAME(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `PAL_ASSERT_NEXT(a_fail_keeps_count, clk, rst_n, cmd.exec && !op_ok,
        count_reg == $past(count_reg))
    `PAL_ASSERT_SAME(a_removed_zero, clk, rst_n,
        done_reg && (status_reg != ST_OK), removed_reg == '0)
    `PAL_ASSERT_SAME(a_no_overlap, clk, rst_n, cmd.exec, !cmd.load && !done_reg)

endmodule

`default_nettype wire

FILE: rtl/positional_array_list_core.sv
// Top level of the positional array list: controller and datapath
// A request accepted in idle is loaded into the input registers, then executed, and its result is registered with done.
// A new request is not taken until the last result has been shown; busy covers execute and result cycles.
// The entry cells shift up or down all at once in the execute state.
// Reset clears the entry count and control state; entry cells stay undefined.
// The result is shown for one cycle on done and cannot be held off.
`default_nettype none

module positional_array_list_core
    import pal_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  mode,
    input  wire logic [POS_W-1:0]      position,
    input  wire logic [DATA_WIDTH-1:0] value,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [DATA_WIDTH-1:0]      removed_value,
    output logic [CNT_W-1:0]           count
);

    pal_cmd_t  cmd;
    pal_stat_t stat;

    pal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    pal_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .mode          (mode),
        .position      (position),
        .value         (value),
        .stat          (stat),
        .status        (status),
        .removed_value (removed_value),
        .count         (count)
    );

    assign done = stat.done;

endmodule

`default_nettype wire
